/* src/mi3_pkg.sv */
// Package for the 3x3 matrix inverse: widths, cofactor index tables and the result type.
package mi3_pkg;

    localparam int ElemW  = 32;             // Q16.16 element
    localparam int ProdW  = 64;             // Q32.32 product and cofactor
    localparam int DetW   = 98;             // Q50.48 determinant
    localparam int NumW   = 96;             // cofactor magnitude scaled by 2^32
    localparam int QW     = 33;             // quotient bits kept before saturation
    localparam int NumEl  = 9;
    // input, products, cofactors, partial products, determinant, prep, divider
    localparam int NumStages = 6 + QW;

    typedef logic signed [ElemW-1:0] t_elem;
    typedef logic signed [ProdW-1:0] t_cof;

    // Cofactor k is a[Pa]*a[Pb] - a[Ma]*a[Mb], elements numbered row by row from 0.
    localparam int CofPa [NumEl] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CofPb [NumEl] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CofMa [NumEl] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CofMb [NumEl] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    localparam logic [ElemW-1:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [ElemW-1:0] SatNeg = 32'h8000_0000;

    typedef struct packed {
        logic [NumEl-1:0][ElemW-1:0] b;
        logic [ElemW-1:0]            det;
        logic                        sing;
    } t_res;

endpackage

/* src/matrix_inverse_3x3_top.sv */
// Pipelined 3x3 matrix inverse by the adjugate, signed Q16.16 in and out.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  input    | i_in_valid / o_in_ready    | i_a11 .. i_a33
//  output   | o_out_valid / i_out_ready  | o_b11 .. o_b33, o_det_out, o_singular
//
// One matrix enters per cycle while o_in_ready is high, and each result then passes
// through every stage to the output register. Six stages form the products, cofactors
// and the determinant, and the restoring divider adds 33 more, one quotient bit each.
// Reset is synchronous and clears only the valid bits of the stages, the output and the skid register.
// A stalled output parks one result in a skid register; the whole pipeline then
// holds until the skid register drains, so nothing is lost or repeated.
module matrix_inverse_3x3_top
    import mi3_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_elem i_a11,
    input  t_elem i_a12,
    input  t_elem i_a13,
    input  t_elem i_a21,
    input  t_elem i_a22,
    input  t_elem i_a23,
    input  t_elem i_a31,
    input  t_elem i_a32,
    input  t_elem i_a33,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_elem o_b11,
    output t_elem o_b12,
    output t_elem o_b13,
    output t_elem o_b21,
    output t_elem o_b22,
    output t_elem o_b23,
    output t_elem o_b31,
    output t_elem o_b32,
    output t_elem o_b33,
    output t_elem o_det_out,
    output logic  o_singular
);

    localparam int ExtW = DetW + QW;

    logic ce;
    logic [NumStages-1:0] r_vld;

    t_elem w_a   [NumEl];
    t_elem r_a   [NumEl];
    t_cof  r_p   [2*NumEl];
    t_elem r_m1  [3];
    t_cof  r_cof2 [NumEl];
    t_elem r_m2  [3];
    logic signed [ProdW:0]   r_pl [3];
    t_cof                    r_ph [3];
    t_cof                    r_cof3 [NumEl];
    logic signed [DetW-1:0]  r_det;
    t_cof                    r_cof4 [NumEl];

    // Divider stage arrays: index 0 is the prep stage, index t has quotient bit QW-t done.
    logic [NumW-1:0]  r_rem  [QW+1][NumEl];
    logic [QW-1:0]    r_q    [QW+1][NumEl];
    logic             r_ng   [QW+1][NumEl];
    logic             r_ov   [QW+1][NumEl];
    logic [DetW-1:0]  r_dm   [QW+1];
    logic [ElemW-1:0] r_dout [QW+1];
    logic             r_sing [QW+1];

    logic signed [DetW-1:0] n_det;
    logic                   n_dneg;
    logic [DetW-1:0]        n_dmag;
    logic [DetW:0]          n_rsum;
    logic [DetW-32:0]       n_dq;
    logic [ElemW-1:0]       n_dout;
    logic [ProdW-1:0]       n_cm [NumEl];

    t_res n_fin;
    t_res r_out;
    t_res r_skid;
    logic r_ovld;
    logic r_skid_vld;
    logic out_take;

    assign w_a[0] = i_a11;
    assign w_a[1] = i_a12;
    assign w_a[2] = i_a13;
    assign w_a[3] = i_a21;
    assign w_a[4] = i_a22;
    assign w_a[5] = i_a23;
    assign w_a[6] = i_a31;
    assign w_a[7] = i_a32;
    assign w_a[8] = i_a33;

    assign ce         = !r_skid_vld;
    assign o_in_ready = ce;
    assign out_take   = r_ovld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[NumStages-2:0], i_in_valid};
        end
    end

    // Front stages: capture, products, cofactors, partial products and sum of the determinant.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < NumEl; k++) begin
                r_a[k]       <= w_a[k];
                r_p[2*k]     <= r_a[CofPa[k]] * r_a[CofPb[k]];
                r_p[2*k+1]   <= r_a[CofMa[k]] * r_a[CofMb[k]];
                r_cof2[k]    <= r_p[2*k] - r_p[2*k+1];
                r_cof3[k]    <= r_cof2[k];
                r_cof4[k]    <= r_cof3[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_m1[j] <= r_a[j];
                r_m2[j] <= r_m1[j];
                // The 64-bit cofactor is split so that each multiply stays within 32 by 33 bits.
                r_pl[j] <= r_m2[j] * $signed({1'b0, r_cof2[3*j][31:0]});
                r_ph[j] <= r_m2[j] * $signed(r_cof2[3*j][63:32]);
            end
            r_det <= n_det;
        end
    end

    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (DetW'(r_ph[j]) <<< 32) + DetW'(r_pl[j]);
        end
    end

    // Prep stage: magnitudes, signs, singular flag, overflow screen and the rounded determinant.
    always_comb begin
        n_dneg = r_det[DetW-1];
        n_dmag = n_dneg ? DetW'(-r_det) : DetW'(r_det);
        n_rsum = {1'b0, n_dmag} + (DetW+1)'(SatNeg);
        n_dq   = n_rsum[DetW:32];
        if (!n_dneg) begin
            n_dout = (n_dq > (DetW-31)'(SatPos)) ? SatPos : n_dq[ElemW-1:0];
        end else begin
            n_dout = (n_dq > (DetW-31)'(SatNeg)) ? SatNeg : ElemW'(-n_dq[ElemW-1:0]);
        end
        for (int k = 0; k < NumEl; k++) begin
            n_cm[k] = r_cof4[k][ProdW-1] ? ProdW'(-r_cof4[k]) : ProdW'(r_cof4[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dm[0]   <= n_dmag;
            r_dout[0] <= n_dout;
            r_sing[0] <= (r_det == '0);
            for (int k = 0; k < NumEl; k++) begin
                r_rem[0][k] <= {n_cm[k], 32'd0};
                r_q[0][k]   <= '0;
                r_ng[0][k]  <= (r_cof4[k][ProdW-1] != n_dneg) && (n_cm[k] != '0);
                // A quotient of 2^33 or more saturates whatever its rounding.
                r_ov[0][k]  <= {{(DetW-ProdW+1){1'b0}}, n_cm[k]} >= {n_dmag, 1'b0};
            end
        end
    end

    // Restoring divider, one quotient bit per stage, nine lanes sharing the divisor.
    for (genvar t = 1; t <= QW; t++) begin : g_div
        localparam int Sh = QW - t;
        logic [ExtW-1:0] w_dsh;
        logic            w_ge [NumEl];

        assign w_dsh = {{QW{1'b0}}, r_dm[t-1]} << Sh;

        always_comb begin
            for (int k = 0; k < NumEl; k++) begin
                w_ge[k] = {{(ExtW-NumW){1'b0}}, r_rem[t-1][k]} >= w_dsh;
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dm[t]   <= r_dm[t-1];
                r_dout[t] <= r_dout[t-1];
                r_sing[t] <= r_sing[t-1];
                for (int k = 0; k < NumEl; k++) begin
                    r_rem[t][k] <= w_ge[k] ? r_rem[t-1][k] - w_dsh[NumW-1:0] : r_rem[t-1][k];
                    r_q[t][k]   <= r_q[t-1][k] | ({{(QW-1){1'b0}}, w_ge[k]} << Sh);
                    r_ng[t][k]  <= r_ng[t-1][k];
                    r_ov[t][k]  <= r_ov[t-1][k];
                end
            end
        end
    end

    // Finish: round half away from zero, saturate, and zero a singular result.
    always_comb begin
        logic       rnd;
        logic [QW:0] q34;
        n_fin.det  = r_dout[QW];
        n_fin.sing = r_sing[QW];
        for (int k = 0; k < NumEl; k++) begin
            rnd = {2'b00, r_rem[QW][k], 1'b0} >= {1'b0, r_dm[QW]};
            q34 = {1'b0, r_q[QW][k]} + {{QW{1'b0}}, rnd};
            if (r_sing[QW]) begin
                n_fin.b[k] = '0;
            end else if (r_ng[QW][k]) begin
                n_fin.b[k] = (r_ov[QW][k] || q34 > {2'b00, SatNeg}) ? SatNeg
                                                                    : ElemW'(-q34[ElemW-1:0]);
            end else begin
                n_fin.b[k] = (r_ov[QW][k] || q34 > {2'b00, SatPos}) ? SatPos
                                                                    : q34[ElemW-1:0];
            end
        end
        if (r_sing[QW]) begin
            n_fin.det = '0;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld     <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[NumStages-1]) begin
            if (r_ovld && !i_out_ready) begin
                r_skid_vld <= 1'b1;
            end
            r_ovld <= 1'b1;
        end else if (out_take) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (r_vld[NumStages-1]) begin
            if (r_ovld && !i_out_ready) begin
                r_skid <= n_fin;
            end else begin
                r_out <= n_fin;
            end
        end
    end

    assign o_out_valid = r_ovld;
    assign o_b11       = r_out.b[0];
    assign o_b12       = r_out.b[1];
    assign o_b13       = r_out.b[2];
    assign o_b21       = r_out.b[3];
    assign o_b22       = r_out.b[4];
    assign o_b23       = r_out.b[5];
    assign o_b31       = r_out.b[6];
    assign o_b32       = r_out.b[7];
    assign o_b33       = r_out.b[8];
    assign o_det_out   = r_out.det;
    assign o_singular  = r_out.sing;

endmodule

/* src/mi3_chk.sv */
// Port-level checker for the 3x3 matrix inverse and its bind to the top level.
module mi3_chk
    import mi3_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_in_ready,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_elem o_b11,
    input t_elem o_b22,
    input t_elem o_b33,
    input t_elem o_det_out,
    input logic  o_singular
);

    // A result that is not taken stays valid, with o_det_out and o_b11 unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_det_out) && $stable(o_b11))
        else $error("output item changed while stalled");

    // The input side only stalls while a result is waiting at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // A singular result carries zeros in o_det_out, o_b11, o_b22 and o_b33.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> o_det_out == '0 && o_b11 == '0 && o_b22 == '0
                                      && o_b33 == '0)
        else $error("singular item with nonzero fields");

    // Reset empties the output and the skid register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output not empty after reset");

endmodule

bind matrix_inverse_3x3_top mi3_chk u_mi3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_b11       (o_b11),
    .o_b22       (o_b22),
    .o_b33       (o_b33),
    .o_det_out   (o_det_out),
    .o_singular  (o_singular)
);
